FILE: design/lcd3w_pkg.sv
// Package for the 3-wire segment-LCD frame serializer.
// Word types, request codes and frame constants; no dependencies.
package lcd3w_pkg;

  localparam int unsigned FrameBits   = 13;
  localparam int unsigned CountW      = 4;
  localparam int unsigned AddrW       = 6;
  localparam int unsigned NibbleBits  = 4;

  localparam logic [2:0] REQ_COMMAND  = 3'd0;
  localparam logic [2:0] REQ_WRITE    = 3'd1;
  localparam logic [2:0] REQ_BURST    = 3'd2;
  localparam logic [2:0] REQ_SEG_ON   = 3'd3;
  localparam logic [2:0] REQ_SEG_OFF  = 3'd4;

  localparam logic [1:0] SEL_NONE     = 2'd3;

  localparam logic [2:0] ADDR_BITS_MAX   = 3'd6;
  localparam logic [2:0] ADDR_BITS_RESET = 3'd6;

  localparam logic [2:0] REG_ADDR_BITS = 3'd0;

  localparam logic [2:0] HEAD_CMD   = 3'b100;
  localparam logic [2:0] HEAD_WRITE = 3'b101;

  localparam logic [CountW-1:0] CMD_COUNT    = 4'd12;
  localparam logic [CountW-1:0] NIBBLE_COUNT = 4'd4;
  localparam logic [CountW-1:0] HEAD_COUNT   = 4'd7;

  typedef struct packed {
    logic [2:0] req_type;
    logic [1:0] piece;
    logic [7:0] command_code;
    logic [5:0] ram_address;
    logic [3:0] nibble;
    logic [2:0] seg_index;
    logic [1:0] com_index;
    logic       burst_last;
  } in_word_t;

  typedef struct packed {
    logic [1:0] select_line;
    logic       data_bit;
    logic       frame_end;
    logic       last;
  } out_word_t;

  typedef struct packed {
    logic [FrameBits-1:0] bits;
    logic [CountW-1:0]    count;
    logic [1:0]           sel;
    logic                 frame_end;
  } frame_t;

endpackage

FILE: design/lcd3w_front.sv
// Request front end: classifies words, keeps burst and shadow state, builds frames.
// Depends on lcd3w_pkg.
module lcd3w_front #(
  parameter int unsigned SHADOW_DEPTH = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [2:0]           addr_bits_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  lcd3w_pkg::in_word_t  in_word_i,
  input  logic                 q_full_i,
  output logic                 push_o,
  output lcd3w_pkg::frame_t    frame_o
);

  localparam int unsigned IdxW = (SHADOW_DEPTH > 1) ? $clog2(SHADOW_DEPTH) : 1;
  localparam logic [5:0] Depth = 6'(SHADOW_DEPTH);

  logic [3:0] shadow_q [SHADOW_DEPTH];
  logic [3:0] shadow_d;
  logic       burst_open_q, burst_open_d;
  logic [1:0] burst_sel_q, burst_sel_d;

  logic             accept;
  logic             known;
  logic             is_seg;
  logic [5:0]       seg_ext;
  logic [IdxW-1:0]  seg_idx;
  logic [3:0]       com_mask;
  logic [2:0]       n_addr;
  logic [5:0]       head_addr;
  logic [3:0]       nib;
  logic [3:0]       nib_rev;
  logic [8:0]       head_word;
  logic [8:0]       head_trim;
  logic [12:0]      write_seq;
  logic [3:0]       write_count;
  logic             continuing;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  assign seg_ext = 6'(in_word_i.seg_index);
  assign seg_idx = seg_ext[IdxW-1:0];
  assign is_seg  = (in_word_i.req_type == lcd3w_pkg::REQ_SEG_ON) ||
                   (in_word_i.req_type == lcd3w_pkg::REQ_SEG_OFF);
  assign known   = (in_word_i.req_type <= lcd3w_pkg::REQ_SEG_OFF) &&
                   !(is_seg && (seg_ext >= Depth));

  assign com_mask = 4'b0001 << in_word_i.com_index;
  assign shadow_d = (in_word_i.req_type == lcd3w_pkg::REQ_SEG_ON)
                  ? (shadow_q[seg_idx] | com_mask)
                  : (shadow_q[seg_idx] & ~com_mask);

  assign n_addr     = (addr_bits_i > lcd3w_pkg::ADDR_BITS_MAX) ? lcd3w_pkg::ADDR_BITS_MAX
                                                                : addr_bits_i;
  assign head_addr  = is_seg ? seg_ext : in_word_i.ram_address;
  assign nib        = is_seg ? shadow_d : in_word_i.nibble;
  assign nib_rev    = {nib[0], nib[1], nib[2], nib[3]};
  assign head_word  = {lcd3w_pkg::HEAD_WRITE, head_addr};
  assign head_trim  = head_word >> (lcd3w_pkg::ADDR_BITS_MAX - n_addr);
  assign write_count = lcd3w_pkg::HEAD_COUNT + 4'(n_addr);
  assign write_seq  = {head_trim, nib_rev} << (4'(lcd3w_pkg::FrameBits) - write_count);
  assign continuing = (in_word_i.req_type == lcd3w_pkg::REQ_BURST) && burst_open_q;

  always_comb begin
    burst_open_d    = burst_open_q;
    burst_sel_d     = burst_sel_q;
    frame_o.sel     = in_word_i.piece;
    frame_o.frame_end = 1'b1;
    frame_o.bits    = write_seq;
    frame_o.count   = write_count;
    if (known) begin
      if (in_word_i.req_type != lcd3w_pkg::REQ_BURST) begin
        burst_open_d = 1'b0;
        burst_sel_d  = lcd3w_pkg::SEL_NONE;
      end
      case (in_word_i.req_type)
        lcd3w_pkg::REQ_COMMAND: begin
          frame_o.bits  = {lcd3w_pkg::HEAD_CMD, in_word_i.command_code, 2'b00};
          frame_o.count = lcd3w_pkg::CMD_COUNT;
        end
        lcd3w_pkg::REQ_BURST: begin
          if (continuing) begin
            frame_o.sel   = burst_sel_q;
            frame_o.bits  = {nib_rev, 9'd0};
            frame_o.count = lcd3w_pkg::NIBBLE_COUNT;
          end
          frame_o.frame_end = in_word_i.burst_last;
          if (in_word_i.burst_last) begin
            burst_open_d = 1'b0;
            burst_sel_d  = lcd3w_pkg::SEL_NONE;
          end else begin
            burst_open_d = 1'b1;
            burst_sel_d  = continuing ? burst_sel_q : in_word_i.piece;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign push_o = accept && known;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      burst_open_q <= 1'b0;
      burst_sel_q  <= lcd3w_pkg::SEL_NONE;
      for (int i = 0; i < SHADOW_DEPTH; i++) begin
        shadow_q[i] <= 4'd0;
      end
    end else if (push_o) begin
      burst_open_q <= burst_open_d;
      burst_sel_q  <= burst_sel_d;
      if (is_seg) begin
        shadow_q[seg_idx] <= shadow_d;
      end
    end
  end

endmodule

FILE: design/lcd3w_fifo.sv
// Two-entry frame queue between the front end and the bit serializer.
// Depends on lcd3w_pkg.
module lcd3w_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  lcd3w_pkg::frame_t frame_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              head_valid_o,
  output lcd3w_pkg::frame_t head_o
);

  lcd3w_pkg::frame_t mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o       = (cnt_q == 2'd2);
  assign head_valid_o = (cnt_q != 2'd0);
  assign head_o       = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= frame_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wr_q <= !wr_q;
      end
      if (pop_i) begin
        rd_q <= !rd_q;
      end
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule

FILE: design/lcd3w_back.sv
// Bit serializer: shifts queued frames out one strobe word per cycle while the output is not stalled.
// Depends on lcd3w_pkg.
module lcd3w_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 head_valid_i,
  input  lcd3w_pkg::frame_t    head_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output lcd3w_pkg::out_word_t out_word_o
);

  lcd3w_pkg::frame_t    cur_q, cur_d, src;
  lcd3w_pkg::out_word_t out_q, out_d;
  logic act_q, act_d;
  logic ov_q, ov_d;
  logic slot_free;
  logic have;
  logic final_bit;

  assign slot_free = !ov_q || out_ready_i;
  assign src       = act_q ? cur_q : head_i;
  assign have      = act_q || head_valid_i;
  assign final_bit = (src.count == 4'd1);
  assign pop_o     = slot_free && !act_q && head_valid_i;

  always_comb begin
    cur_d = cur_q;
    act_d = act_q;
    ov_d  = ov_q;
    out_d = out_q;
    if (slot_free) begin
      ov_d = have;
      if (have) begin
        out_d.select_line = src.sel;
        out_d.data_bit    = src.bits[lcd3w_pkg::FrameBits-1];
        out_d.last        = final_bit;
        out_d.frame_end   = final_bit && src.frame_end;
        cur_d.bits        = src.bits << 1;
        cur_d.count       = src.count - 4'd1;
        cur_d.sel         = src.sel;
        cur_d.frame_end   = src.frame_end;
        act_d             = !final_bit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= 1'b0;
      ov_q  <= 1'b0;
    end else begin
      act_q <= act_d;
      ov_q  <= ov_d;
    end
  end

  assign out_valid_o = ov_q;
  assign out_word_o  = out_q;

endmodule

FILE: design/lcd_3wire_frame_serializer_unit.sv
// Top level of the 3-wire segment-LCD frame serializer: APB register, front end,
// frame queue and bit serializer. Depends on lcd3w_pkg, lcd3w_front, lcd3w_fifo, lcd3w_back.
//
//   channel | handshake              | payload
//   in      | in_valid_i / in_ready_o | in_word_i  (lcd3w_pkg::in_word_t)
//   out     | out_valid_o/out_ready_i | out_word_o (lcd3w_pkg::out_word_t)
//   cfg     | psel/penable/pwrite     | paddr, pwdata, prdata (addr_bits at 0x0)
//
// One output word per cycle unless the output stalls; a request yields 4 to 13 words.
// The front end takes a request per cycle while the two-entry frame queue has room.
// Reset is asynchronous, clears burst state and shadow nibbles and sets addr_bits to 6.
// Either side may stall; the queue and the output register absorb it.
module lcd_3wire_frame_serializer_unit #(
  parameter int unsigned SHADOW_DEPTH = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  lcd3w_pkg::in_word_t  in_word_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output lcd3w_pkg::out_word_t out_word_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  logic [2:0]        addr_bits_q;
  logic              q_full;
  logic              push;
  logic              pop;
  logic              head_valid;
  lcd3w_pkg::frame_t frame;
  lcd3w_pkg::frame_t head;

  assign pready = 1'b1;
  assign prdata = (paddr == lcd3w_pkg::REG_ADDR_BITS) ? {29'd0, addr_bits_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_bits_q <= lcd3w_pkg::ADDR_BITS_RESET;
    end else if (psel && penable && pwrite && pready &&
                 (paddr == lcd3w_pkg::REG_ADDR_BITS)) begin
      addr_bits_q <= pwdata[2:0];
    end
  end

  lcd3w_front #(
    .SHADOW_DEPTH(SHADOW_DEPTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .addr_bits_i (addr_bits_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .frame_o     (frame)
  );

  lcd3w_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .frame_i      (frame),
    .full_o       (q_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  lcd3w_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_word_o   (out_word_o)
  );

endmodule

FILE: design/lcd3w_checker.sv
// Port-level checks for the 3-wire segment-LCD frame serializer, bound to its top level.
// Depends on lcd3w_pkg and lcd_3wire_frame_serializer_unit.
module lcd3w_port_checks (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input lcd3w_pkg::out_word_t out_word_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_word_o))
    else $error("output word changed while stalled");

  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.frame_end |-> out_word_o.last)
    else $error("frame end on a word that is not last");

  a_bits_follow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !out_word_o.last |=>
      out_valid_o && (out_word_o.select_line == $past(out_word_o.select_line)))
    else $error("gap or select change inside one request");

  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("output valid during reset");

endmodule

bind lcd_3wire_frame_serializer_unit lcd3w_port_checks u_lcd3w_port_checks (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_word_o  (out_word_o)
);
